// File: rtl/core/raw_slot_table_lookup_top_macros.svh
// Assertion macros used by the slot table checker.
`ifndef RAW_SLOT_TABLE_LOOKUP_TOP_MACROS_SVH
`define RAW_SLOT_TABLE_LOOKUP_TOP_MACROS_SVH

// Checked while out of reset.
`define RSTL_ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slot table check failed");

// Checked at every edge, reset included.
`define RSTL_ASSERT_ALL(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("slot table reset check failed");

`endif

// File: rtl/core/rstl_pkg.sv
// Types and constants of the slot table lookup block.
package rstl_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_REPLACE = 2'd1,
    KIND_DELETE  = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_DEL_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_Q_RD,
    S_Q_EVAL,
    S_Q_MUL,
    S_Q_ACC,
    S_MOD,
    S_FMUL,
    S_FADD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  ctrl;
    logic [15:0] slot;
    logic [23:0] group;
  } entry_t;

  // Datapath to controller.
  typedef struct packed {
    logic wr_ok;
    logic idx_ok;
    logic del_more;
    logic walk_more;
    logic found;
    logic n_zero;
    logic mod_last;
    logic out_free;
  } dp_stat_t;

  // Controller to datapath.
  typedef struct packed {
    logic    idle;
    logic    load;
    logic    wr_entry;
    logic    del_rd;
    logic    del_wr;
    logic    del_fin;
    logic    q_rd;
    logic    q_eval;
    logic    q_mul;
    logic    q_acc;
    logic    mod_step;
    logic    fmul;
    logic    fadd;
    logic    st_we;
    status_t st;
    logic    out_load;
  } ctl_cmd_t;

  localparam int unsigned ID_MSB = 12;
  localparam logic [17:0] DUR_STEP = 18'd120;
  localparam logic [17:0] DUR_BASE = 18'd500;
  localparam logic [24:0] START_MAX = 25'h1FF_FFFF;

endpackage

// File: rtl/core/rstl_ctrl.sv
// Controller state machine of the slot table lookup block.
module rstl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rstl_pkg::kind_t   in_kind,
  input  rstl_pkg::dp_stat_t stat,
  output rstl_pkg::ctl_cmd_t cmd
);
  import rstl_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_APPEND, KIND_REPLACE: state_nxt = S_WRITE;
            KIND_DELETE:               state_nxt = S_DEL_CHK;
            KIND_QUERY:                state_nxt = S_Q_RD;
            default:                   state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRITE:   state_nxt = S_DONE;
      S_DEL_CHK: state_nxt = stat.idx_ok ? S_DEL_RD : S_DONE;
      S_DEL_RD:  state_nxt = stat.del_more ? S_DEL_WR : S_DONE;
      S_DEL_WR:  state_nxt = S_DEL_RD;
      S_Q_RD: begin
        priority if (stat.walk_more) state_nxt = S_Q_EVAL;
        else if (!stat.found || stat.n_zero) state_nxt = S_DONE;
        else state_nxt = S_MOD;
      end
      S_Q_EVAL:  state_nxt = S_Q_MUL;
      S_Q_MUL:   state_nxt = S_Q_ACC;
      S_Q_ACC:   state_nxt = S_Q_RD;
      S_MOD:     state_nxt = stat.mod_last ? S_FMUL : S_MOD;
      S_FMUL:    state_nxt = S_FADD;
      S_FADD:    state_nxt = S_DONE;
      S_DONE:    state_nxt = stat.out_free ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    cmd.st = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        cmd.load = in_valid;
      end
      S_WRITE: begin
        cmd.st_we = 1'b1;
        cmd.wr_entry = stat.wr_ok;
        cmd.st = stat.wr_ok ? ST_OK : ST_RANGE;
      end
      S_DEL_CHK: begin
        cmd.st_we = 1'b1;
        cmd.st = stat.idx_ok ? ST_OK : ST_RANGE;
      end
      S_DEL_RD: begin
        cmd.del_rd = stat.del_more;
        cmd.del_fin = !stat.del_more;
      end
      S_DEL_WR: cmd.del_wr = 1'b1;
      S_Q_RD: begin
        cmd.q_rd = 1'b1;
        cmd.st_we = !stat.walk_more;
        priority if (!stat.found) cmd.st = ST_NOMATCH;
        else if (stat.n_zero) cmd.st = ST_ZERO;
        else cmd.st = ST_OK;
      end
      S_Q_EVAL:  cmd.q_eval = 1'b1;
      S_Q_MUL:   cmd.q_mul = 1'b1;
      S_Q_ACC:   cmd.q_acc = 1'b1;
      S_MOD:     cmd.mod_step = 1'b1;
      S_FMUL:    cmd.fmul = 1'b1;
      S_FADD:    cmd.fadd = 1'b1;
      S_DONE:    cmd.out_load = stat.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/rstl_dp.sv
// Datapath of the slot table lookup block: entry memory, walk and result registers.
module rstl_dp #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rstl_pkg::ctl_cmd_t cmd,
  output rstl_pkg::dp_stat_t stat,
  input  logic [1:0]         in_kind,
  input  logic [3:0]         in_entry_index,
  input  logic [7:0]         in_control_byte,
  input  logic [15:0]        in_slot_word,
  input  logic [23:0]        in_group_word,
  input  logic [12:0]        in_station_id,
  input  logic [3:0]         in_match_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [4:0]         out_entry_count,
  output logic [4:0]         out_match_count,
  output logic [3:0]         out_match_position,
  output logic [24:0]        out_slot_start_us,
  output logic [17:0]        out_slot_length_us,
  output logic [5:0]         out_slot_number,
  output logic [1:0]         out_access_type,
  output logic               out_format_bit,
  output logic               out_cross_bit,
  output logic [1:0]         out_page_number
);
  import rstl_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  // Latched item.
  kind_t       kind_r;
  logic [3:0]  idx_r;
  entry_t      new_r;
  logic [12:0] id_r;
  logic [3:0]  want_r;

  logic [CW-1:0] held_r;
  logic [CW-1:0] ptr_r;
  logic [CW:0]   ptr_inc;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  // Walk state.
  logic [CW-1:0] cnt_r;
  logic          found_r;
  logic [AW-1:0] pos_r;
  logic [24:0]   acc_r;
  logic [24:0]   before_r;
  logic [17:0]   dur_r;
  logic [5:0]    n_r;
  logic [23:0]   prod_r;
  logic [17:0]   sel_dur_r;
  logic [5:0]    sel_n_r;
  logic [1:0]    sel_acc_r;
  logic          sel_fmt_r;
  logic          sel_cross_r;
  logic [1:0]    sel_page_r;
  logic [6:0]    rem_r;
  logic [3:0]    bit_r;
  logic [24:0]   start_r;
  status_t       st_r;

  // Decode of the entry just read.
  logic        e_fmt;
  logic [10:0] e_cnt;
  logic [5:0]  e_n;
  logic [17:0] e_dur;
  logic        e_match;
  logic        e_take;
  logic [25:0] acc_sum;
  logic [25:0] start_sum;
  logic [6:0]  rem_sh;
  logic [7:0]  idx_ext;
  logic [7:0]  held_ext;

  // Result register.
  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic [4:0]  o_entry_count_r;
  logic [4:0]  o_match_count_r;
  logic [3:0]  o_pos_r;
  logic [24:0] o_start_r;
  logic [17:0] o_len_r;
  logic [5:0]  o_num_r;
  logic [1:0]  o_acc_r;
  logic        o_fmt_r;
  logic        o_cross_r;
  logic [1:0]  o_page_r;
  logic        o_sel;
  logic        o_full;

  assign ptr_inc  = {1'b0, ptr_r} + (CW+1)'(1);
  assign idx_ext  = 8'(idx_r);
  assign held_ext = 8'(held_r);

  // Status toward the controller.
  always_comb begin
    stat.idx_ok    = idx_ext < held_ext;
    stat.wr_ok     = (kind_r == KIND_APPEND) ? (held_ext < 8'(MAX_ENTRIES)) : stat.idx_ok;
    stat.del_more  = ptr_inc < {1'b0, held_r};
    stat.walk_more = ptr_r < held_r;
    stat.found     = found_r;
    stat.n_zero    = sel_n_r == 6'd0;
    stat.mod_last  = bit_r == 4'd0;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // Entry field decode.
  always_comb begin
    e_fmt   = rd_data_r.slot[15];
    e_cnt   = e_fmt ? rd_data_r.slot[13:3] : {3'd0, rd_data_r.slot[13:6]};
    e_n     = e_fmt ? {3'd0, rd_data_r.slot[2:0]} : rd_data_r.slot[5:0];
    e_dur   = 18'(18'(e_cnt) * DUR_STEP + DUR_BASE);
    e_match = (id_r >= {3'd0, rd_data_r.group[11:2]}) &&
              (id_r <= {3'd0, rd_data_r.group[22:13]});
    e_take  = e_match && !found_r && (8'(cnt_r) == 8'(want_r));
  end

  // Saturating sums and one remainder step.
  assign acc_sum   = 26'(acc_r) + 26'(prod_r);
  assign start_sum = 26'(before_r) + 26'(prod_r);
  always_comb begin
    rem_sh = {rem_r[5:0], id_r[bit_r]};
    if (rem_sh >= {1'b0, sel_n_r}) begin
      rem_sh = rem_sh - {1'b0, sel_n_r};
    end
  end

  // Memory port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r[AW-1:0];
    mem_wd = rd_data_r;
    mem_re = cmd.del_rd || (cmd.q_rd && stat.walk_more);
    mem_ra = cmd.del_rd ? ptr_inc[AW-1:0] : ptr_r[AW-1:0];
    if (cmd.wr_entry) begin
      mem_we = 1'b1;
      mem_wd = new_r;
      mem_wa = (kind_r == KIND_APPEND) ? held_r[AW-1:0] : AW'(idx_r);
    end else if (cmd.del_wr) begin
      mem_we = 1'b1;
    end
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Entry count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.wr_entry && (kind_r == KIND_APPEND)) begin
      held_r <= held_r + CW'(1);
    end else if (cmd.del_fin) begin
      held_r <= held_r - CW'(1);
    end
  end

  // Item latch, walk and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind_t'(in_kind);
      idx_r   <= in_entry_index;
      new_r   <= '{ctrl: in_control_byte, slot: in_slot_word, group: in_group_word};
      id_r    <= in_station_id;
      want_r  <= in_match_number;
      ptr_r   <= (kind_t'(in_kind) == KIND_DELETE) ? CW'(in_entry_index) : '0;
      cnt_r   <= '0;
      found_r <= 1'b0;
      acc_r   <= '0;
      sel_n_r <= '0;
    end
    if (cmd.del_wr || cmd.q_acc) begin
      ptr_r <= ptr_inc[CW-1:0];
    end
    if (cmd.q_eval) begin
      dur_r <= e_dur;
      n_r   <= e_n;
      if (e_match) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (e_take) begin
        found_r     <= 1'b1;
        pos_r       <= ptr_r[AW-1:0];
        before_r    <= acc_r;
        sel_dur_r   <= e_dur;
        sel_n_r     <= e_n;
        sel_acc_r   <= rd_data_r.ctrl[1:0];
        sel_fmt_r   <= e_fmt;
        sel_cross_r <= rd_data_r.slot[14];
        sel_page_r  <= rd_data_r.group[1:0];
      end
    end
    if (cmd.q_mul) begin
      prod_r <= {6'd0, dur_r} * {18'd0, n_r};
    end
    if (cmd.q_acc && !found_r) begin
      acc_r <= acc_sum[25] ? START_MAX : acc_sum[24:0];
    end
    if (cmd.q_rd && !stat.walk_more) begin
      rem_r <= '0;
      bit_r <= 4'(ID_MSB);
    end
    if (cmd.mod_step) begin
      rem_r <= rem_sh;
      bit_r <= bit_r - 4'd1;
    end
    if (cmd.fmul) begin
      prod_r <= {6'd0, sel_dur_r} * {18'd0, rem_r[5:0]};
    end
    if (cmd.fadd) begin
      start_r <= start_sum[25] ? START_MAX : start_sum[24:0];
    end
    if (cmd.st_we) begin
      st_r <= cmd.st;
    end
  end

  // Result register: holds until the receiver takes it.
  assign o_sel  = (kind_r == KIND_QUERY) && (st_r != ST_NOMATCH);
  assign o_full = (kind_r == KIND_QUERY) && (st_r == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status_r      <= st_r;
      o_entry_count_r <= 5'(held_r);
      o_match_count_r <= (kind_r == KIND_QUERY) ? 5'(cnt_r) : 5'd0;
      o_pos_r         <= o_sel ? 4'(pos_r) : 4'd0;
      o_len_r         <= o_sel ? sel_dur_r : 18'd0;
      o_acc_r         <= o_sel ? sel_acc_r : 2'd0;
      o_fmt_r         <= o_sel && sel_fmt_r;
      o_cross_r       <= o_sel && sel_cross_r;
      o_page_r        <= o_sel ? sel_page_r : 2'd0;
      o_start_r       <= o_full ? start_r : 25'd0;
      o_num_r         <= o_full ? rem_r[5:0] : 6'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_entry_count    = o_entry_count_r;
  assign out_match_count    = o_match_count_r;
  assign out_match_position = o_pos_r;
  assign out_slot_start_us  = o_start_r;
  assign out_slot_length_us = o_len_r;
  assign out_slot_number    = o_num_r;
  assign out_access_type    = o_acc_r;
  assign out_format_bit     = o_fmt_r;
  assign out_cross_bit      = o_cross_r;
  assign out_page_number    = o_page_r;

endmodule

// File: rtl/core/raw_slot_table_lookup_top.sv
// Top level of the slot table lookup block.
//
// The input channel carries one item: append, replace or delete of a table
// entry, or a query of a station id. Every item gives exactly one result on
// the output channel, with a status and the entry count after the item.
// The block works on one item at a time; in_stall is high from the cycle
// after an item is taken until its result has entered the output register.
// Append and replace write the entry in a single write state. A delete checks
// the index, then moves each later entry down with a read step and a write
// step. A query walks every held entry through read, decode, multiply and
// accumulate steps, then runs the modulo (one id bit per cycle) and the final
// multiply, add and hand-off.
// The output register frees the datapath: the next item is taken while a
// result still waits behind out_stall, and its own result waits in the
// controller until the register is free. A stalled result holds steady.
// Reset empties the table and drops out_valid; entry contents are not
// cleared, since no entry beyond the count is ever read.
module raw_slot_table_lookup_top #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_entry_index,
  input  logic [7:0]  in_control_byte,
  input  logic [15:0] in_slot_word,
  input  logic [23:0] in_group_word,
  input  logic [12:0] in_station_id,
  input  logic [3:0]  in_match_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [4:0]  out_entry_count,
  output logic [4:0]  out_match_count,
  output logic [3:0]  out_match_position,
  output logic [24:0] out_slot_start_us,
  output logic [17:0] out_slot_length_us,
  output logic [5:0]  out_slot_number,
  output logic [1:0]  out_access_type,
  output logic        out_format_bit,
  output logic        out_cross_bit,
  output logic [1:0]  out_page_number
);
  import rstl_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer.
  rstl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (kind_t'(in_kind)),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table and arithmetic.
  rstl_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_entry_index     (in_entry_index),
    .in_control_byte    (in_control_byte),
    .in_slot_word       (in_slot_word),
    .in_group_word      (in_group_word),
    .in_station_id      (in_station_id),
    .in_match_number    (in_match_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_match_count    (out_match_count),
    .out_match_position (out_match_position),
    .out_slot_start_us  (out_slot_start_us),
    .out_slot_length_us (out_slot_length_us),
    .out_slot_number    (out_slot_number),
    .out_access_type    (out_access_type),
    .out_format_bit     (out_format_bit),
    .out_cross_bit      (out_cross_bit),
    .out_page_number    (out_page_number)
  );

  // Items are taken only while the sequencer is idle.
  assign in_stall = !cmd.idle;

endmodule

// File: rtl/core/rstl_checker.sv
// Port checker of the slot table lookup block and its bind.
`include "raw_slot_table_lookup_top_macros.svh"

module rstl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [24:0] out_slot_start_us
);

  // A stalled result keeps its status and start time.
  `RSTL_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_slot_start_us))

  // One item at a time: a taken item closes the input for the next cycle.
  `RSTL_ASSERT_RUN(a_one_item, in_valid && !in_stall |=> in_stall)

  // An item taken while no result is pending does not raise out_valid straight away.
  `RSTL_ASSERT_RUN(a_accept_no_result, in_valid && !in_stall && !out_valid |=> !out_valid)

  // Reset drops any pending result.
  `RSTL_ASSERT_ALL(a_reset_clear, !rst_n |=> !out_valid)

endmodule

bind raw_slot_table_lookup_top rstl_checker u_rstl_checker (.*);
